// ===== hw/rtl/mhpq_pkg.sv =====
// Shared types, codes and helpers for the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

	localparam int HEAP_CAPACITY_DEF = 127;
	localparam int WORD_W = 32;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_PEEK   = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] priority_req;
		logic [15:0] process_id;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  count;
		logic        head_valid;
		logic [15:0] head_priority;
		logic [15:0] head_id;
	} rsp_beat_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_UP_RD,
		SQ_UP_CMP,
		SQ_DN_LAST,
		SQ_DN_LOAD,
		SQ_DN_RDL,
		SQ_DN_RDR,
		SQ_DN_PICK,
		SQ_DN_CMP,
		SQ_PLACE,
		SQ_FINISH
	} seq_state_t;

	// Priority sits above the id, so one unsigned compare gives queue order.
	function automatic logic word_less(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		return a < b;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 127,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mhpq_sift.sv =====
// Heap sequencer: sift-up and sift-down over the heap RAM with one comparator.
`default_nettype none

module mhpq_sift #(
	parameter int HEAP_CAPACITY = mhpq_pkg::HEAP_CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire mhpq_pkg::req_beat_t req,
	output logic                     ready,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output mhpq_pkg::rsp_beat_t      res
);

	import mhpq_pkg::*;

	localparam int SW = $clog2(HEAP_CAPACITY + 1);
	localparam int AW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;

	seq_state_t state_q, state_d;

	logic [SW-1:0]     cnt_q;
	logic [SW-1:0]     pos_q;
	logic [SW-1:0]     kid_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] best_q;
	logic [WORD_W-1:0] head_q;
	logic [1:0]        status_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic [WORD_W-1:0] cmp_a, cmp_b;
	logic              lt;

	logic [SW:0]       kid_w;
	logic [SW:0]       kid_m1;
	logic              full;
	logic              has_right;

	function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s);
		logic [SW-1:0] t;
		t = s - SW'(1);
		return t[AW-1:0];
	endfunction

	assign lt        = word_less(cmp_a, cmp_b);
	assign kid_w     = {pos_q, 1'b0};
	assign kid_m1    = {pos_q - SW'(1), 1'b1};
	assign full      = (cnt_q == SW'(HEAP_CAPACITY));
	assign has_right = (kid_q < cnt_q);

	mhpq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(HEAP_CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (start) begin
					priority if (req.command == CMD_INSERT) begin
						state_d = full ? SQ_FINISH : SQ_UP_RD;
					end else if (req.command == CMD_DELETE) begin
						state_d = (cnt_q == '0) ? SQ_FINISH : SQ_DN_LAST;
					end else begin
						state_d = SQ_FINISH;
					end
				end
			end
			SQ_UP_RD:   state_d = (pos_q > SW'(1)) ? SQ_UP_CMP : SQ_PLACE;
			SQ_UP_CMP:  state_d = lt ? SQ_UP_RD : SQ_PLACE;
			SQ_DN_LAST: state_d = SQ_DN_LOAD;
			SQ_DN_LOAD: state_d = SQ_DN_RDL;
			SQ_DN_RDL:  state_d = (kid_w > {1'b0, cnt_q}) ? SQ_PLACE : SQ_DN_RDR;
			SQ_DN_RDR:  state_d = has_right ? SQ_DN_PICK : SQ_DN_CMP;
			SQ_DN_PICK: state_d = SQ_DN_CMP;
			SQ_DN_CMP:  state_d = lt ? SQ_DN_RDL : SQ_PLACE;
			SQ_PLACE:   state_d = SQ_FINISH;
			SQ_FINISH:  state_d = res_ready ? SQ_IDLE : SQ_FINISH;
			default:    state_d = SQ_IDLE;
		endcase
	end

	// RAM ports and comparator operands
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_addr(pos_q);
		ram_wdata = word_q;
		ram_raddr = '0;
		cmp_a     = word_q;
		cmp_b     = ram_rdata;
		unique case (state_q)
			SQ_UP_RD: begin
				ram_raddr = slot_addr(pos_q >> 1);
			end
			SQ_UP_CMP: begin
				ram_we    = lt;
				ram_wdata = ram_rdata;
			end
			SQ_DN_LAST: begin
				ram_raddr = slot_addr(cnt_q);
			end
			SQ_DN_RDL: begin
				ram_raddr = kid_m1[AW-1:0];
			end
			SQ_DN_RDR: begin
				ram_raddr = kid_q[AW-1:0];
			end
			SQ_DN_PICK: begin
				cmp_a = ram_rdata;
				cmp_b = best_q;
			end
			SQ_DN_CMP: begin
				cmp_a     = best_q;
				cmp_b     = word_q;
				ram_we    = lt;
				ram_wdata = best_q;
			end
			SQ_PLACE: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SQ_IDLE && start && req.command == CMD_INSERT && !full) begin
				cnt_q <= cnt_q + SW'(1);
			end else if (state_q == SQ_DN_LOAD) begin
				cnt_q <= cnt_q - SW'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			SQ_IDLE: begin
				word_q <= {req.priority_req, req.process_id};
				pos_q  <= cnt_q + SW'(1);
				if (req.command == CMD_INSERT && full) begin
					status_q <= ST_FULL;
				end else if (req.command == CMD_DELETE && cnt_q == '0) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= ST_DONE;
				end
			end
			SQ_UP_CMP: begin
				if (lt) begin
					pos_q <= pos_q >> 1;
				end
			end
			SQ_DN_LOAD: begin
				word_q <= ram_rdata;
				pos_q  <= SW'(1);
			end
			SQ_DN_RDL: begin
				kid_q <= kid_w[SW-1:0];
			end
			SQ_DN_RDR: begin
				best_q <= ram_rdata;
			end
			SQ_DN_PICK: begin
				if (lt) begin
					best_q <= ram_rdata;
					kid_q  <= kid_q + SW'(1);
				end
			end
			SQ_DN_CMP: begin
				if (lt) begin
					pos_q <= kid_q;
				end
			end
			default: begin
			end
		endcase
		// keep a copy of the root slot
		if (ram_we && ram_waddr == '0) begin
			head_q <= ram_wdata;
		end
	end

	assign ready     = (state_q == SQ_IDLE);
	assign res_valid = (state_q == SQ_FINISH);

	always_comb begin
		res.status        = status_q;
		res.count         = 7'(cnt_q);
		res.head_valid    = (cnt_q != '0);
		res.head_priority = (cnt_q != '0) ? head_q[31:16] : 16'd0;
		res.head_id       = (cnt_q != '0) ? head_q[15:0] : 16'd0;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SW'(HEAP_CAPACITY))
		else $error("entry count above capacity");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != SQ_IDLE && state_q != SQ_FINISH && pos_q != '0))
		else $error("heap write outside a sift or to slot zero");

	a_start_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(ready && start) |=> (state_q != SQ_IDLE))
		else $error("accepted beat did not start the sequencer");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> (cnt_q == SW'($past(cnt_q) + SW'(1)) ||
			cnt_q == SW'($past(cnt_q) - SW'(1))))
		else $error("entry count moved by more than one");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(cnt_q)))
		else $error("pending result dropped");

endmodule

`default_nettype wire

// ===== hw/rtl/min_heap_priority_queue.sv =====
// Timing: peek and refused beats go straight to the result; insert time grows with each level
//   climbed and delete time with each level descended. Sift rate is set by the single-read-port
//   heap RAM and one comparator.
// Throughput: one beat at a time; the next request beat is taken once the result beat has
//   moved into the output register, so any output stall also holds off the next request.
// Reset (arst_n low): heap empty, no result pending; RAM contents are not cleared.
`default_nettype none

module min_heap_priority_queue #(
	parameter int HEAP_CAPACITY = mhpq_pkg::HEAP_CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire mhpq_pkg::req_beat_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output mhpq_pkg::rsp_beat_t      rsp
);

	import mhpq_pkg::*;

	logic      eng_ready;
	logic      eng_start;
	logic      res_valid;
	logic      res_ready;
	rsp_beat_t res;

	logic      rsp_valid_q;
	rsp_beat_t rsp_q;

	// Take a request beat only while the sequencer sits idle.
	assign req_stall = !eng_ready;
	assign eng_start = req_valid && eng_ready;

	mhpq_sift #(
		.HEAP_CAPACITY(HEAP_CAPACITY)
	) u_sift (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (eng_start),
		.req      (req),
		.ready    (eng_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register: load when empty or being drained this cycle.
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold the payload while stalled; advance only on a fresh result.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
